// ===== rtl/lst_pkg.sv =====
// Package for the LCD scanline mode timer: timing constants, mode codes and types.
package lst_pkg;

  localparam int unsigned DOTS_PER_LINE = 456;
  localparam int unsigned OAM_SCAN_END  = 80;
  localparam int unsigned DRAW_END      = 252;
  localparam int unsigned VISIBLE_LINES = 144;
  localparam int unsigned LAST_LINE     = 153;

  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_DRAW   = 2'd3;

  localparam logic REG_LCD_ENABLE   = 1'b0;
  localparam logic REG_LINE_COMPARE = 1'b1;

  typedef struct packed {
    logic       lcd_enable;
    logic [7:0] line_compare;
  } lst_cfg_t;

endpackage

// ===== rtl/lst_cfg_regs.sv =====
// Configuration register file with APB-style access for the LCD scanline mode timer.
module lst_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output lst_pkg::lst_cfg_t cfg
);
  import lst_pkg::*;

  logic       lcd_enable_r;
  logic [7:0] line_compare_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcd_enable_r   <= 1'b0;
      line_compare_r <= 8'd0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_LCD_ENABLE:   lcd_enable_r   <= pwdata[0];
        REG_LINE_COMPARE: line_compare_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (paddr[2])
      REG_LCD_ENABLE:   prdata = {31'd0, lcd_enable_r};
      REG_LINE_COMPARE: prdata = {24'd0, line_compare_r};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg.lcd_enable   = lcd_enable_r;
  assign cfg.line_compare = line_compare_r;

endmodule

// ===== rtl/lst_timing_core.sv =====
// Input register, dot and line counter update, mode decode and result register.
module lst_timing_core (
  input  logic              clk,
  input  logic              rst_n,
  input  lst_pkg::lst_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_cycles,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_mode,
  output logic [7:0]        out_line,
  output logic              out_coincidence,
  output logic              out_vblank_request
);
  import lst_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_cycles_r;
  logic [8:0] dot_r, dot_nxt;
  logic [7:0] line_r, line_nxt;
  logic       coin_r, coin_nxt;
  logic       vblank_nxt;
  logic [1:0] mode_nxt;
  logic       out_valid_r;
  logic [1:0] out_mode_r;
  logic [7:0] out_line_r;
  logic       out_coin_r;
  logic       out_vblank_r;
  logic       advance;
  logic [9:0] dot_sum;
  logic [8:0] line_inc;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;

  always_comb begin
    dot_sum    = {1'b0, dot_r} + {2'b00, s1_cycles_r};
    line_inc   = {1'b0, line_r} + 9'd1;
    dot_nxt    = dot_sum[8:0];
    line_nxt   = line_r;
    coin_nxt   = coin_r;
    vblank_nxt = 1'b0;
    if (!cfg.lcd_enable) begin
      dot_nxt  = 9'd0;
      line_nxt = 8'd0;
    end else if (dot_sum >= 10'(DOTS_PER_LINE)) begin
      dot_nxt    = 9'(dot_sum - 10'(DOTS_PER_LINE));
      vblank_nxt = (line_inc == 9'(VISIBLE_LINES));
      line_nxt   = (line_inc > 9'(LAST_LINE)) ? 8'd0 : line_inc[7:0];
      coin_nxt   = (line_nxt == cfg.line_compare);
    end
    if (!cfg.lcd_enable)
      mode_nxt = MODE_HBLANK;
    else if ({1'b0, line_nxt} >= 9'(VISIBLE_LINES))
      mode_nxt = MODE_VBLANK;
    else if (dot_nxt < 9'(OAM_SCAN_END))
      mode_nxt = MODE_OAM;
    else if (dot_nxt < 9'(DRAW_END))
      mode_nxt = MODE_DRAW;
    else
      mode_nxt = MODE_HBLANK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      dot_r       <= 9'd0;
      line_r      <= 8'd0;
      coin_r      <= 1'b0;
    end else begin
      if (!in_stall)
        s1_valid_r <= in_valid;
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          dot_r  <= dot_nxt;
          line_r <= line_nxt;
          coin_r <= coin_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall)
      s1_cycles_r <= in_cycles;
    if (advance && s1_valid_r) begin
      out_mode_r   <= mode_nxt;
      out_line_r   <= line_nxt;
      out_coin_r   <= coin_nxt;
      out_vblank_r <= vblank_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mode           = out_mode_r;
  assign out_line           = out_line_r;
  assign out_coincidence    = out_coin_r;
  assign out_vblank_request = out_vblank_r;

  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, out_line_r} <= 9'(LAST_LINE)))
    else $error("line beyond last line");

  a_vblank_line: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_vblank_r) |->
      ({1'b0, out_line_r} == 9'(VISIBLE_LINES) && out_mode_r == MODE_VBLANK))
    else $error("vblank request off line entry");

  a_vblank_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && {1'b0, out_line_r} >= 9'(VISIBLE_LINES)) |-> out_mode_r == MODE_VBLANK)
    else $error("mode not vblank outside visible area");

  a_dot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dot_r < 9'(DOTS_PER_LINE))
    else $error("dot counter overflow");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room in pipeline");

endmodule

// ===== rtl/lcd_scanline_mode_timer.sv =====
// LCD scanline mode timer: top level joining configuration registers and timing core.
//
// Input channel (in_valid / in_stall / in_cycles): each transaction carries the
// number of dot clocks elapsed since the previous one. Result channel
// (out_valid / out_stall / out_*): one transaction per input, giving the mode,
// the current line, the line-compare flag and a one-shot vblank request.
// An accepted input passes through the input register, then the result register,
// to out_valid; one transaction is taken every cycle while in_stall is low, with
// the dot add, line compare and mode decode done combinationally in between.
// A stalled result is held in the output register while one further input is
// still accepted into the input register; in_stall rises only once both hold
// data and out_stall is high.
// Reset (rst_n low, synchronous) empties the pipeline, zeroes the dot counter,
// line and compare flag, and clears lcd_enable and line_compare. The APB-style
// port holds lcd_enable at 0x0 and line_compare at 0x4; write only while idle.
module lcd_scanline_mode_timer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_cycles,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_mode,
  output logic [7:0]  out_line,
  output logic        out_coincidence,
  output logic        out_vblank_request
);
  import lst_pkg::*;

  lst_cfg_t cfg;

  lst_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lst_timing_core u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cycles          (in_cycles),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_mode           (out_mode),
    .out_line           (out_line),
    .out_coincidence    (out_coincidence),
    .out_vblank_request (out_vblank_request)
  );

endmodule

// ===== tb/sv/lcd_scanline_mode_timer_tb.sv =====
// Testbench for lcd_scanline_mode_timer: directed table, random frames and a timing predictor.
`timescale 1ns / 1ps

module lcd_scanline_mode_timer_tb;
  import lst_pkg::*;

  localparam int PIPE_LATENCY = 2;
  localparam int DIR_ROWS = 19;
  localparam int NUM_PHASES = 6;
  localparam int MAX_REPORTS = 40;
  localparam logic [2:0] ADDR_LCD_ENABLE = {REG_LCD_ENABLE, 2'b00};
  localparam logic [2:0] ADDR_LINE_COMPARE = {REG_LINE_COMPARE, 2'b00};

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] line;
    logic       coin;
    logic       vbl;
  } timing_res_t;

  typedef struct packed {
    logic        wr;
    logic        en;
    logic [7:0]  cmp;
    logic [7:0]  cyc;
    logic        typed;
    timing_res_t res;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_cycles = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_mode;
  logic [7:0]  out_line;
  logic        out_coincidence;
  logic        out_vblank_request;

  lcd_scanline_mode_timer DUT (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_cycles(in_cycles),
    .out_valid(out_valid), .out_stall(out_stall), .out_mode(out_mode),
    .out_line(out_line), .out_coincidence(out_coincidence),
    .out_vblank_request(out_vblank_request)
  );

  always #5 clk = ~clk;

  // predictor state and its copy of the registers
  logic       tm_enable = 1'b0;
  logic [7:0] tm_cmp = '0;
  logic [8:0] tm_dots = '0;
  logic [7:0] tm_line = '0;
  logic       tm_coin = 1'b0;

  timing_res_t expected_timing_q[$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int vblank_pulses = 0;
  int frame_wraps = 0;
  int coin_lines = 0;
  int settings_run = 0;
  bit long_hold_done = 1'b0;

  step_row_t dir_tab [DIR_ROWS] = '{
    '{1'b0, 1'b0, 8'd0, 8'd255, 1'b1, '{MODE_HBLANK, 8'd0, 1'b0, 1'b0}},
    '{1'b0, 1'b0, 8'd0, 8'd0,   1'b1, '{MODE_HBLANK, 8'd0, 1'b0, 1'b0}},
    '{1'b1, 1'b1, 8'd1, 8'd0,   1'b1, '{MODE_OAM,    8'd0, 1'b0, 1'b0}},
    '{1'b0, 1'b0, 8'd0, 8'd79,  1'b1, '{MODE_OAM,    8'd0, 1'b0, 1'b0}},
    '{1'b0, 1'b0, 8'd0, 8'd1,   1'b1, '{MODE_DRAW,   8'd0, 1'b0, 1'b0}},
    '{1'b0, 1'b0, 8'd0, 8'd171, 1'b1, '{MODE_DRAW,   8'd0, 1'b0, 1'b0}},
    '{1'b0, 1'b0, 8'd0, 8'd1,   1'b1, '{MODE_HBLANK, 8'd0, 1'b0, 1'b0}},
    '{1'b0, 1'b0, 8'd0, 8'd203, 1'b1, '{MODE_HBLANK, 8'd0, 1'b0, 1'b0}},
    '{1'b0, 1'b0, 8'd0, 8'd1,   1'b1, '{MODE_OAM,    8'd1, 1'b1, 1'b0}},
    // new compare value must not be applied until the next line change
    '{1'b1, 1'b1, 8'd3, 8'd255, 1'b1, '{MODE_HBLANK, 8'd1, 1'b1, 1'b0}},
    '{1'b0, 1'b0, 8'd0, 8'd255, 1'b0, '0},
    '{1'b0, 1'b0, 8'd0, 8'd255, 1'b0, '0},
    '{1'b0, 1'b0, 8'd0, 8'd255, 1'b0, '0},
    // display off: counters cleared, flag held
    '{1'b1, 1'b0, 8'd0, 8'd128, 1'b1, '{MODE_HBLANK, 8'd0, 1'b1, 1'b0}},
    '{1'b1, 1'b1, 8'd0, 8'd0,   1'b1, '{MODE_OAM,    8'd0, 1'b1, 1'b0}},
    '{1'b0, 1'b0, 8'd0, 8'd255, 1'b0, '0},
    '{1'b0, 1'b0, 8'd0, 8'd255, 1'b0, '0},
    '{1'b0, 1'b0, 8'd0, 8'd0,   1'b0, '0},
    '{1'b0, 1'b0, 8'd0, 8'd128, 1'b0, '0}
  };

  function automatic timing_res_t predict_timing(input logic [7:0] cyc);
    int unsigned sum;
    logic [8:0]  nxt;
    timing_res_t r;
    r = '0;
    if (!tm_enable) begin
      tm_dots = '0;
      tm_line = '0;
      r.mode = MODE_HBLANK;
    end else begin
      sum = tm_dots + cyc;
      if (sum >= DOTS_PER_LINE) begin
        sum = sum - DOTS_PER_LINE;
        nxt = {1'b0, tm_line} + 9'd1;
        if (nxt == VISIBLE_LINES) begin
          r.vbl = 1'b1;
          vblank_pulses++;
        end
        if (nxt > LAST_LINE) begin
          nxt = '0;
          frame_wraps++;
        end
        tm_line = nxt[7:0];
        tm_coin = (tm_line == tm_cmp);
        if (tm_coin) coin_lines++;
      end
      tm_dots = sum[8:0];
      if (tm_line >= VISIBLE_LINES) r.mode = MODE_VBLANK;
      else if (tm_dots < OAM_SCAN_END) r.mode = MODE_OAM;
      else if (tm_dots < DRAW_END) r.mode = MODE_DRAW;
      else r.mode = MODE_HBLANK;
      r.line = tm_line;
    end
    r.coin = tm_coin;
    return r;
  endfunction

  task automatic check_field(input string what, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      if (errors < MAX_REPORTS)
        $display("%0t: %s expected %0d got %0d", $time, what, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    timing_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_timing_q.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: unexpected transaction, expected none got line %0d", $time, out_line);
        errors++;
      end else begin
        e = expected_timing_q.pop_front();
        check_field("mode", e.mode, out_mode);
        check_field("line", e.line, out_line);
        check_field("coincidence", e.coin, out_coincidence);
        check_field("vblank_request", e.vbl, out_vblank_request);
      end
    end
  end

  task automatic apb_write_check(input logic [2:0] addr, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field("register readback", val, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timing_cfg(input logic en, input logic [7:0] cmp);
    apb_write_check(ADDR_LCD_ENABLE, {31'b0, en});
    apb_write_check(ADDR_LINE_COMPARE, {24'b0, cmp});
    tm_enable = en;
    tm_cmp = cmp;
    settings_run++;
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_timing_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic send_cycles(input logic [7:0] cyc, input logic typed, input timing_res_t fixed);
    timing_res_t r;
    in_valid <= 1'b1;
    in_cycles <= cyc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_timing(cyc);
    expected_timing_q.push_back(typed ? fixed : r);
    items_sent++;
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pick_cycles;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    if (sel <= 5) return 8'($urandom_range(192, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  // receiver: runs of free flow, light and heavy stall, plus one long hold-off
  initial begin
    int run;
    int pct;
    int held;
    forever begin
      if (!long_hold_done && results_seen >= 400) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        for (held = 0; held < 300; held++) @(posedge clk);
      end
      run = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0: pct = 0;
        1: pct = 50;
        default: pct = 85;
      endcase
      repeat (run) begin
        out_stall <= ($urandom_range(0, 99) < pct);
        @(posedge clk);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic       ph_en  [NUM_PHASES];
    logic [7:0] ph_cmp [NUM_PHASES];
    int         ph_len [NUM_PHASES];
    int         burst;
    int         p;
    int         k;
    ph_en  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    ph_cmp = '{8'd0, 8'd153, 8'($urandom_range(0, 255)), 8'd144, 8'd255,
               8'($urandom_range(0, 153))};
    ph_len = '{350, 300, 40, 300, 100, 300};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < DIR_ROWS; k++) begin
      if (dir_tab[k].wr) begin
        wait_drained();
        set_timing_cfg(dir_tab[k].en, dir_tab[k].cmp);
      end
      send_cycles(dir_tab[k].cyc, dir_tab[k].typed, dir_tab[k].res);
      idle_gap($urandom_range(0, 2));
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      set_timing_cfg(ph_en[p], ph_cmp[p]);
      burst = $urandom_range(1, 40);
      for (k = 0; k < ph_len[p]; k++) begin
        if (p == 0 && k == ph_len[p] / 2) wait_drained();
        send_cycles(pick_cycles(), 1'b0, '0);
        burst--;
        if (burst == 0) begin
          burst = $urandom_range(1, 40);
          if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
        end
      end
    end

    wait_drained();
    if (expected_timing_q.size() != 0) begin
      $display("%0t: %0d expected transactions never arrived", $time,
               expected_timing_q.size());
      errors++;
    end
    $display("Covered %0d transactions under %0d register settings, with readback.",
             items_sent, settings_run);
    $display("Saw %0d vblank pulses, %0d frame wraps and %0d compare matches.",
             vblank_pulses, frame_wraps, coin_lines);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lst_pkg.sv
rtl/lst_cfg_regs.sv
rtl/lst_timing_core.sv
rtl/lcd_scanline_mode_timer.sv
tb/sv/lcd_scanline_mode_timer_tb.sv
